// ===== rtl/uwbm_pkg.sv =====
// shared constants, types and byte-lane helpers of the byte-addressed word memory
package uwbm_pkg;

  localparam int FUNC_W         = 2;
  localparam int ADDR_W         = 16;
  localparam int DATA_W         = 64;
  localparam int STATUS_W       = 2;
  localparam int BYTES_PER_WORD = 8;
  localparam int OFF_W          = $clog2(BYTES_PER_WORD);
  localparam int IDX_W          = ADDR_W - OFF_W;
  localparam int DEFAULT_WORDS  = 8192;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ_WORD  = 2'd0,
    FUNC_READ_BYTE  = 2'd1,
    FUNC_WRITE_WORD = 2'd2,
    FUNC_WRITE_BYTE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_ADDR  = 2'd1,
    STATUS_UNALIGNED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_SECOND
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    status_t           status;
  } res_t;

  // bytes off..7 of lo followed by bytes 0..off-1 of hi
  function automatic logic [DATA_W-1:0] join_words(input logic [DATA_W-1:0] lo,
                                                   input logic [DATA_W-1:0] hi,
                                                   input logic [OFF_W-1:0]  off);
    logic [2*DATA_W-1:0] both;
    both = {hi, lo} >> {off, 3'b000};
    return both[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] extract_byte(input logic [DATA_W-1:0] w,
                                                     input logic [OFF_W-1:0]  off);
    logic [DATA_W-1:0] sh;
    sh = w >> {off, 3'b000};
    return {{(DATA_W-8){1'b0}}, sh[7:0]};
  endfunction

  function automatic logic [DATA_W-1:0] merge_byte(input logic [DATA_W-1:0] w,
                                                   input logic [7:0]        b,
                                                   input logic [OFF_W-1:0]  off);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] lane;
    mask = {{(DATA_W-8){1'b0}}, 8'hff} << {off, 3'b000};
    lane = {{(DATA_W-8){1'b0}}, b} << {off, 3'b000};
    return (w & ~mask) | lane;
  endfunction

endpackage

// ===== rtl/uwbm_if.sv =====
// valid/ready channel interfaces for requests and responses
interface uwbm_req_if;
  logic                        valid;
  logic                        ready;
  logic [uwbm_pkg::FUNC_W-1:0] func;
  logic [uwbm_pkg::ADDR_W-1:0] address;
  logic [uwbm_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output func, output address, output write_data,
                  input ready);
  modport sink   (input valid, input func, input address, input write_data,
                  output ready);
endinterface

interface uwbm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [uwbm_pkg::DATA_W-1:0]   read_data;
  logic [uwbm_pkg::STATUS_W-1:0] status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink   (input valid, input read_data, input status, output ready);
endinterface

// ===== rtl/uwbm_ram.sv =====
// single-port synchronous ram with registered read data
module uwbm_ram #(
  parameter int DEPTH = uwbm_pkg::DEFAULT_WORDS,
  parameter int WIDTH = uwbm_pkg::DATA_W + 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/uwbm_seq.sv =====
// access sequencer: clear sweep, read-modify-write and result formation
module uwbm_seq #(
  parameter int WORDS = uwbm_pkg::DEFAULT_WORDS
) (
  input  logic           clk,
  input  logic           rst,
  uwbm_req_if.sink       req,
  input  logic           slot_free,
  output uwbm_pkg::res_t res
);
  import uwbm_pkg::*;

  localparam int AW = $clog2(WORDS);
  localparam int CW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  state_t            state, state_next;
  logic [AW-1:0]     clr_idx;
  func_t             func_q;
  logic [OFF_W-1:0]  off_q;
  logic [CW-1:0]     idx_q;
  logic [DATA_W-1:0] wdata_q;
  logic              rng0_q, rng1_q;
  logic [DATA_W-1:0] w0_q;

  logic [CW-1:0]     in_idx, in_idx1, idx1_q;
  logic              in_rng0, in_rng1, accept, load_w0;

  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W:0]   ram_wdata, ram_rdata;
  logic              v_rd;
  logic [DATA_W-1:0] d_rd;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_idx    = CW'(req.address[ADDR_W-1:OFF_W]);
  assign in_idx1   = in_idx + CW'(1);
  assign in_rng0   = in_idx < CW'(WORDS);
  assign in_rng1   = in_idx1 < CW'(WORDS);
  assign idx1_q    = idx_q + CW'(1);
  assign v_rd      = ram_rdata[DATA_W];
  assign d_rd      = ram_rdata[DATA_W-1:0];

  uwbm_ram #(.DEPTH(WORDS), .WIDTH(DATA_W + 1)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func_t'(req.func);
      off_q   <= req.address[OFF_W-1:0];
      idx_q   <= in_idx;
      wdata_q <= req.write_data;
      rng0_q  <= in_rng0;
      rng1_q  <= in_rng1;
    end
    if (load_w0) begin
      w0_q <= d_rd;
    end
  end

  always_comb begin
    state_next = state;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = idx_q[AW-1:0];
    ram_wdata  = '0;
    load_w0    = 1'b0;
    res.valid  = 1'b0;
    res.data   = '0;
    res.status = STATUS_OK;
    case (state)
      ST_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_idx;
        if (clr_idx == AW'(WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ram_en     = in_rng0;
          ram_addr   = in_idx[AW-1:0];
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        res.valid = 1'b1;
        case (func_q)
          FUNC_READ_WORD: begin
            if (!(rng0_q && v_rd) || (off_q != '0 && !rng1_q)) begin
              res.status = STATUS_BAD_ADDR;
            end else if (off_q == '0) begin
              res.data = d_rd;
            end else begin
              // straddles two words: fetch the next one
              res.valid = 1'b0;
              load_w0   = 1'b1;
              ram_en    = 1'b1;
              ram_addr  = idx1_q[AW-1:0];
            end
          end
          FUNC_READ_BYTE: begin
            if (rng0_q && v_rd) begin
              res.data = extract_byte(d_rd, off_q);
            end else begin
              res.status = STATUS_BAD_ADDR;
            end
          end
          FUNC_WRITE_WORD: begin
            if (off_q != '0) begin
              res.status = STATUS_UNALIGNED;
            end else if (!rng0_q) begin
              res.status = STATUS_BAD_ADDR;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, wdata_q};
            end
          end
          FUNC_WRITE_BYTE: begin
            if (!rng0_q) begin
              res.status = STATUS_BAD_ADDR;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, merge_byte(v_rd ? d_rd : '0, wdata_q[7:0], off_q)};
            end
          end
          default: begin
            res.status = STATUS_BAD_ADDR;
          end
        endcase
        if (!res.valid) begin
          state_next = ST_SECOND;
        end else if (slot_free) begin
          ram_en     = ram_we;
          state_next = ST_IDLE;
        end else begin
          // hold until the output slot frees; write commits only on exit
          ram_we = 1'b0;
        end
      end
      ST_SECOND: begin
        res.valid = 1'b1;
        if (v_rd) begin
          res.data = join_words(w0_q, d_rd, off_q);
        end else begin
          res.status = STATUS_BAD_ADDR;
        end
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_res_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == ST_FIRST || state == ST_SECOND))
    else $error("result offered outside an access");

  a_accept_to_first: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_FIRST))
    else $error("accepted transfer did not start an access");

  a_write_on_exit: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_CLEAR) |-> (res.valid && slot_free && res.status == STATUS_OK))
    else $error("memory written without delivering an ok result");

  a_error_zero_data: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != STATUS_OK) |-> (res.data == '0))
    else $error("error result carries data");

  a_unaligned_kind: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == STATUS_UNALIGNED) |-> (func_q == FUNC_WRITE_WORD))
    else $error("unaligned status on a non word write");
`endif

endmodule

// ===== rtl/unaligned_word_byte_memory.sv =====
// top level of the little-endian byte-addressed word memory with valid marks
//
// usage:
// - req channel carries func, address and write_data; a transfer happens when
//   valid and ready are both high. rsp channel returns read_data and status,
//   exactly one response per request, in request order.
// - func: read word (may be unaligned), read byte, write aligned word, write
//   byte. status: ok, invalid address (unwritten word or past the store), or
//   unaligned word write. read_data is zero on any error and on writes.
// - the response is registered in the output register after the ram read,
//   and after a second read for a word read that straddles two stored words.
// - a new request is taken only once the last one's result has left the
//   sequencer, as the single ram port serves one read, then write-back or a second read.
// - after reset the valid marks of all WORDS words (8192 by default) are
//   swept clear, one word per cycle; req.ready stays low during the sweep.
// - if the receiver stalls, a finished response waits in the output
//   register while the next request is already taken and read; that request
//   then holds, with its write not yet committed, until the register frees.
module unaligned_word_byte_memory #(
  parameter int WORDS = uwbm_pkg::DEFAULT_WORDS
) (
  input  logic      clk,
  input  logic      rst,
  uwbm_req_if.sink  req,
  uwbm_rsp_if.source rsp
);
  import uwbm_pkg::*;

  res_t              res;
  logic              slot_free;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  status_t           out_status;

  // output register frees when empty or being taken this cycle
  assign slot_free = !out_valid || rsp.ready;

  // sequencer owns the memory and the clear sweep
  uwbm_seq #(.WORDS(WORDS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .slot_free (slot_free),
    .res       (res)
  );

  // control bit of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res.valid;
    end
  end

  // payload of the output register, loaded as a response moves in
  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      out_data   <= res.data;
      out_status <= res.status;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;
  assign rsp.status    = out_status;

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the byte-addressed word memory: directed and random accesses
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uwbm_pkg::*;

  localparam int MEM_WORDS  = DEFAULT_WORDS;
  // cycles with no transfer on either side before the run is called hung;
  // the valid-mark sweep after reset has no transfers either
  localparam int QUIET_LIMIT = 3 * MEM_WORDS + 2000;
  // receiver hold-off used to fill the block and stall its request side
  localparam int LONG_HOLD   = 300;
  // cycles to linger after the last response
  localparam int TAIL_CYCLES = 12;

  typedef struct {
    logic [DATA_W-1:0] data;
    status_t           status;
  } mem_reply_t;

  logic clk = 1'b0;
  logic rst;

  uwbm_req_if req_ch ();
  uwbm_rsp_if rsp_ch ();

  unaligned_word_byte_memory u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the memory: word contents plus the written marks
  logic [DATA_W-1:0] shadow_words [MEM_WORDS];
  bit                shadow_marks [MEM_WORDS];

  // responses owed by the block, oldest first
  mem_reply_t replies_due [$];

  int unsigned fail_count  = 0;
  int unsigned quiet_count = 0;

  // idling switches for each side, and the one-shot long hold request
  bit req_idle_on  = 1'b0;
  bit rsp_idle_on  = 1'b0;
  bit hold_request = 1'b0;

  // a word counts as present only if it lies in the store and was written
  function automatic bit word_present(input int unsigned w);
    return (w < MEM_WORDS) && shadow_marks[w];
  endfunction

  // apply one access to the shadow memory and return what the block owes
  function automatic mem_reply_t apply_access(input func_t f, input logic [ADDR_W-1:0] a,
                                              input logic [DATA_W-1:0] d);
    mem_reply_t          r;
    int unsigned         w;
    int unsigned         lane;
    logic [2*DATA_W-1:0] pair;
    logic [DATA_W-1:0]   merged;
    w        = 32'(a[ADDR_W-1:OFF_W]);
    lane     = 32'(a[OFF_W-1:0]);
    r.data   = '0;
    r.status = STATUS_OK;
    case (f)
      FUNC_READ_WORD: begin
        if (!word_present(w)) begin
          r.status = STATUS_BAD_ADDR;
        end else if (lane == 0) begin
          r.data = shadow_words[w];
        end else if (!word_present(w + 1)) begin
          // straddle needs the next word too, which may lie past the store
          r.status = STATUS_BAD_ADDR;
        end else begin
          pair   = {shadow_words[w + 1], shadow_words[w]};
          pair   = pair >> (8 * lane);
          r.data = pair[DATA_W-1:0];
        end
      end
      FUNC_READ_BYTE: begin
        if (!word_present(w)) r.status = STATUS_BAD_ADDR;
        else r.data = {56'd0, shadow_words[w][8*lane +: 8]};
      end
      FUNC_WRITE_WORD: begin
        // alignment is checked ahead of the range
        if (lane != 0) begin
          r.status = STATUS_UNALIGNED;
        end else if (w >= MEM_WORDS) begin
          r.status = STATUS_BAD_ADDR;
        end else begin
          shadow_words[w] = d;
          shadow_marks[w] = 1'b1;
        end
      end
      default: begin
        if (w >= MEM_WORDS) begin
          r.status = STATUS_BAD_ADDR;
        end else begin
          // unwritten bytes of a fresh word read as zero
          merged = shadow_marks[w] ? shadow_words[w] : '0;
          merged[8*lane +: 8] = d[7:0];
          shadow_words[w] = merged;
          shadow_marks[w] = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // one request transfer; the valid stays up afterwards so back-to-back
  // requests never lower and raise it within the same step
  task automatic send_item(input func_t f, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d);
    if (req_idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.address    <= a;
    req_ch.write_data <= d;
    do @(posedge clk); while (!req_ch.ready);
    replies_due.insert(replies_due.size(), apply_access(f, a, d));
  endtask

  // drop valid and wait for every owed response; always advances time
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // mostly a low window and the top of the store so reads find written words;
  // now and then any address at all
  function automatic logic [ADDR_W-1:0] pick_address();
    int          sel;
    int unsigned w;
    sel = $urandom_range(0, 9);
    if (sel == 9) return ADDR_W'($urandom);
    if (sel < 6) w = $urandom_range(0, 47);
    else w = $urandom_range(MEM_WORDS - 32, MEM_WORDS - 1);
    return {IDX_W'(w), OFF_W'($urandom_range(0, 7))};
  endfunction

  task automatic send_random_access();
    func_t             f;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    int                pick;
    f    = func_t'($urandom_range(0, 3));
    a    = pick_address();
    pick = $urandom_range(0, 15);
    if (pick == 0) d = '1;
    else if (pick == 1) d = '0;
    else d = {$urandom, $urandom};
    // most word writes aligned, the rest land wherever the offset falls
    if (f == FUNC_WRITE_WORD && $urandom_range(0, 7) != 0) a[OFF_W-1:0] = '0;
    send_item(f, a, d);
  endtask

  // reads of a memory nothing has been written to yet
  task automatic test_unwritten_reads();
    send_item(FUNC_READ_WORD, 16'h0000, '0);
    send_item(FUNC_READ_WORD, 16'h0003, '0);
    send_item(FUNC_READ_BYTE, 16'hffff, '0);
    wait_for_drain();
  endtask

  // aligned and misaligned word writes, aligned and straddling reads,
  // including the straddle off the end of the store
  task automatic test_word_access();
    send_item(FUNC_WRITE_WORD, 16'h0000, 64'hffff_ffff_ffff_ffff);
    send_item(FUNC_WRITE_WORD, 16'h0008, 64'h0123_4567_89ab_cdef);
    send_item(FUNC_WRITE_WORD, 16'h0015, 64'hdead_beef_dead_beef);
    send_item(FUNC_READ_WORD,  16'h0010, '0);
    send_item(FUNC_WRITE_WORD, 16'hfff8, 64'ha5a5_5a5a_c3c3_3c3c);
    send_item(FUNC_WRITE_WORD, 16'h0010, 64'h0000_0000_0000_0000);
    send_item(FUNC_READ_WORD,  16'h0000, '0);
    send_item(FUNC_READ_WORD,  16'h0001, '0);
    send_item(FUNC_READ_WORD,  16'h0007, '0);
    send_item(FUNC_READ_WORD,  16'h000c, '0);
    send_item(FUNC_READ_WORD,  16'hfff8, '0);
    send_item(FUNC_READ_WORD,  16'hfff9, '0);
    send_item(FUNC_READ_BYTE,  16'h000f, '0);
    wait_for_drain();
  endtask

  // byte writes into fresh and written words, upper data bits ignored
  task automatic test_byte_access();
    send_item(FUNC_WRITE_BYTE, 16'h0100, 64'hffff_ffff_ffff_ff5a);
    send_item(FUNC_READ_WORD,  16'h0100, '0);
    send_item(FUNC_WRITE_BYTE, 16'h0107, 64'h0000_0000_0000_00c3);
    send_item(FUNC_READ_WORD,  16'h0100, '0);
    send_item(FUNC_READ_WORD,  16'h0101, '0);
    send_item(FUNC_WRITE_BYTE, 16'hffff, 64'h1234_5678_9abc_def0);
    send_item(FUNC_READ_BYTE,  16'hffff, '0);
    send_item(FUNC_READ_BYTE,  16'hfffe, '0);
    send_item(FUNC_WRITE_BYTE, 16'h000b, 64'h0000_0000_0000_0077);
    send_item(FUNC_READ_WORD,  16'h0005, '0);
    wait_for_drain();
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_access();
    wait_for_drain();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_response_stall(input int count);
    req_idle_on  = 1'b0;
    hold_request = 1'b1;
    repeat (count) send_random_access();
    wait_for_drain();
  endtask

  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_READ_WORD;
    req_ch.address    <= '0;
    req_ch.write_data <= '0;
    rst               <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_unwritten_reads();
    test_word_access();
    test_byte_access();

    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    test_random_mix(350);
    test_response_stall(40);
    req_idle_on = 1'b1;
    test_random_mix(200);

    // closing stretch runs at full rate on both sides
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    test_random_mix(240);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[unaligned_word_byte_memory] OK");
    end else begin
      $display("[unaligned_word_byte_memory] ERROR");
    end
    $finish;
  end

  // response side: ready high by default, random short stalls, and one long
  // hold-off counted here when asked for
  initial begin : rsp_side
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // compare each response transfer with the oldest owed reply
  always @(posedge clk) begin : check_reply
    mem_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected response: read_data %h status %0d",
               rsp_ch.read_data, rsp_ch.status);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.read_data !== want.data) begin
          $error("read_data: expected %h, actual %h", want.data, rsp_ch.read_data);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
  end

  // hang detection: any transfer on either channel resets the count
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= QUIET_LIMIT) begin
      $display("[unaligned_word_byte_memory] ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/uwbm_pkg.sv
rtl/uwbm_if.sv
rtl/uwbm_ram.sv
rtl/uwbm_seq.sv
rtl/unaligned_word_byte_memory.sv
bench/tb.sv
